// File: rtl/pvb_pkg.sv
// shared types and constants of the point voxel binning unit
package pvb_pkg;

   localparam int X_CELLS_DEF = 64;
   localparam int Y_CELLS_DEF = 64;
   localparam int Z_CELLS_DEF = 64;

   localparam int COORD_W = 20;           // coordinate and register width
   localparam int INDEX_W = 20;           // point index width
   localparam int STEP_W  = 16;           // cell size width
   localparam int OFF_W   = COORD_W + 1;  // difference of two coordinates
   localparam int HIT_W   = 16;
   localparam int HIST_W  = 20;
   localparam int RANGE_W = 20;
   localparam int SQ_W    = 2 * RANGE_W;  // sum of three squares fits here
   localparam int CSR_IW  = 3;
   localparam int CSR_DW  = 20;

   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(10);

   typedef enum logic [CSR_IW-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_TOP_Y    = 3'd1,
      CSR_TOP_Z    = 3'd2,
      CSR_STEP_X   = 3'd3,
      CSR_STEP_Y   = 3'd4,
      CSR_STEP_Z   = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_CALC,
      ST_READ,
      ST_WRITE
   } pvb_state_type;

endpackage

// File: rtl/pvb_if.sv
// request and response channels of the point voxel binning unit
interface pvb_req_if;
   logic                               valid;
   logic                               ready;
   logic [pvb_pkg::INDEX_W-1:0]        point_index;
   logic signed [pvb_pkg::COORD_W-1:0] point_x;
   logic signed [pvb_pkg::COORD_W-1:0] point_y;
   logic signed [pvb_pkg::COORD_W-1:0] point_z;

   modport source (output valid, point_index, point_x, point_y, point_z, input ready);
   modport sink   (input valid, point_index, point_x, point_y, point_z, output ready);
endinterface

interface pvb_rsp_if #(
   parameter int BXW = $clog2(pvb_pkg::X_CELLS_DEF),
   parameter int BYW = $clog2(pvb_pkg::Y_CELLS_DEF),
   parameter int BZW = $clog2(pvb_pkg::Z_CELLS_DEF)
);
   logic                         valid;
   logic                         ready;
   logic [BXW-1:0]               bin_x;
   logic [BYW-1:0]               bin_y;
   logic [BZW-1:0]               bin_z;
   logic [pvb_pkg::HIT_W-1:0]    voxel_hits;
   logic                         new_voxel;
   logic                         front_updated;
   logic [pvb_pkg::RANGE_W-1:0]  point_range;
   logic                         out_of_range;
   logic [pvb_pkg::HIST_W-1:0]   x_hist_count;
   logic [pvb_pkg::HIST_W-1:0]   y_hist_count;
   logic [pvb_pkg::HIST_W-1:0]   z_hist_count;

   modport source (output valid, bin_x, bin_y, bin_z, voxel_hits, new_voxel, front_updated,
                   point_range, out_of_range, x_hist_count, y_hist_count, z_hist_count,
                   input ready);
   modport sink   (input valid, bin_x, bin_y, bin_z, voxel_hits, new_voxel, front_updated,
                   point_range, out_of_range, x_hist_count, y_hist_count, z_hist_count,
                   output ready);
endinterface

// File: rtl/pvb_ram.sv
// generic single write port ram with registered read
module pvb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/pvb_div.sv
// restoring divider, one quotient bit per cycle
module pvb_div #(
   parameter int DW = 21,
   parameter int SW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [SW-1:0] divisor,
   output logic          busy,
   output logic [DW-1:0] quotient
);
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] dvd_ff;
   logic [SW-1:0] rem_ff;
   logic [SW-1:0] dsr_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic [SW:0]   rem_sh;
   logic [SW:0]   diff;
   logic          ge;

   assign rem_sh = {rem_ff, dvd_ff[DW-1]};
   assign diff   = rem_sh - {1'b0, dsr_ff};
   assign ge     = rem_sh >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CW'(1);
         if (cnt_ff == CW'(DW - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DW-2:0], ge};
         rem_ff <= ge ? diff[SW-1:0] : rem_sh[SW-1:0];
      end
   end

   assign busy     = busy_ff;
   assign quotient = dvd_ff;
endmodule

// File: rtl/pvb_root.sv
// range unit: sum of squares on one shared multiplier, then a bit-serial square root
module pvb_root (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [pvb_pkg::COORD_W-1:0] x,
   input  logic signed [pvb_pkg::COORD_W-1:0] y,
   input  logic signed [pvb_pkg::COORD_W-1:0] z,
   output logic                               busy,
   output logic [pvb_pkg::RANGE_W-1:0]        root
);
   import pvb_pkg::*;

   localparam int MUL_STEPS = 4;  // three products plus the last accumulate
   localparam int LAST      = MUL_STEPS + RANGE_W - 1;
   localparam int CW        = $clog2(LAST + 1);
   localparam int REM_W     = RANGE_W + 2;
   localparam int PROD_W    = 2 * COORD_W - 1;

   logic signed [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic signed [COORD_W-1:0] sel;
   logic signed [2*COORD_W-1:0] sq;
   logic [PROD_W-1:0]  prod_ff;
   logic [SQ_W-1:0]    acc_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [RANGE_W-1:0] root_ff;
   logic [CW-1:0]      cnt_ff;
   logic               busy_ff;
   logic [REM_W+1:0]   rem_sh;
   logic [REM_W+1:0]   trial;
   logic               ge;

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    sel = x_ff;
         2'd1:    sel = y_ff;
         2'd2:    sel = z_ff;
         default: sel = '0;
      endcase
   end

   assign sq     = sel * sel;
   assign rem_sh = {rem_ff, acc_ff[SQ_W-1:SQ_W-2]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign ge     = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CW'(1);
         if (cnt_ff == CW'(LAST)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= x;
         y_ff    <= y;
         z_ff    <= z;
         prod_ff <= '0;
         acc_ff  <= '0;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         if (cnt_ff < CW'(MUL_STEPS)) begin
            prod_ff <= sq[PROD_W-1:0];
            acc_ff  <= acc_ff + SQ_W'(prod_ff);
         end else begin
            // one root bit per cycle, two radicand bits in
            acc_ff  <= {acc_ff[SQ_W-3:0], 2'b00};
            rem_ff  <= ge ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
            root_ff <= {root_ff[RANGE_W-2:0], ge};
         end
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;
endmodule

// File: rtl/point_voxel_binning_unit.sv
// top level of the point voxel binning unit
//
//  channel | dir | handshake         | word
//  req_ch  | in  | valid/ready       | point_index, point_x, point_y, point_z
//  rsp_ch  | out | valid/ready       | bins, voxel_hits, flags, point_range, histogram counts
//  csr_*   | in  | csr_we, no ready  | csr_index, csr_wdata
//
//  one point is in flight at a time; the time from accept to result is set by the range unit
//  (three squares on one multiplier, then 20 root iterations)
//  after reset a clearing pass writes every voxel entry, during which req_ch.ready stays low;
//  csr writes are taken throughout
//  a finished word waits in the output register while the next point is accepted;
//  the store write back stalls only if that word has still not been taken
module point_voxel_binning_unit #(
   parameter int X_CELLS = pvb_pkg::X_CELLS_DEF,
   parameter int Y_CELLS = pvb_pkg::Y_CELLS_DEF,
   parameter int Z_CELLS = pvb_pkg::Z_CELLS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   pvb_req_if.sink                     req_ch,
   pvb_rsp_if.source                   rsp_ch,
   input  logic                        csr_we,
   input  logic [pvb_pkg::CSR_IW-1:0]  csr_index,
   input  logic [pvb_pkg::CSR_DW-1:0]  csr_wdata
);
   import pvb_pkg::*;

   localparam int BXW       = $clog2(X_CELLS);
   localparam int BYW       = $clog2(Y_CELLS);
   localparam int BZW       = $clog2(Z_CELLS);
   localparam int FRONTS    = Y_CELLS * Z_CELLS;
   localparam int VOX_DEPTH = X_CELLS * FRONTS;
   localparam int VW        = $clog2(VOX_DEPTH);
   localparam int FW        = $clog2(FRONTS);
   localparam int FMW       = BXW + 1;              // front x bin, all ones when empty
   localparam int VOX_W     = INDEX_W + HIT_W;      // last point, hit count
   localparam int FRT_W     = FMW + INDEX_W + RANGE_W;

   // configuration registers
   logic signed [COORD_W-1:0] origin_x_ff, top_y_ff, top_z_ff;
   logic [STEP_W-1:0]         step_x_ff, step_y_ff, step_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         top_y_ff    <= '0;
         top_z_ff    <= '0;
         step_x_ff   <= STEP_RESET;
         step_y_ff   <= STEP_RESET;
         step_z_ff   <= STEP_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ORIGIN_X: origin_x_ff <= csr_wdata[COORD_W-1:0];
            CSR_TOP_Y:    top_y_ff    <= csr_wdata[COORD_W-1:0];
            CSR_TOP_Z:    top_z_ff    <= csr_wdata[COORD_W-1:0];
            CSR_STEP_X:   step_x_ff   <= csr_wdata[STEP_W-1:0];
            CSR_STEP_Y:   step_y_ff   <= csr_wdata[STEP_W-1:0];
            CSR_STEP_Z:   step_z_ff   <= csr_wdata[STEP_W-1:0];
            default:      ;  // unknown index, write dropped
         endcase
      end
   end

   // control
   pvb_state_type state_ff, state_in;
   logic [VW-1:0] clr_cnt_ff;
   logic          req_take;
   logic          unit_start;
   logic          units_busy;
   logic          rsp_free;
   logic          commit;
   logic          sweep;
   logic          rsp_valid_ff;

   // per point registers
   logic [INDEX_W-1:0]        pidx_ff;
   logic signed [COORD_W-1:0] px_ff, py_ff, pz_ff;
   logic signed [OFF_W-1:0]   off_x_ff, off_y_ff, off_z_ff;
   logic [OFF_W-1:0]          mag_x, mag_y, mag_z;
   logic [OFF_W-1:0]          quo_x, quo_y, quo_z;
   logic                      busy_x, busy_y, busy_z, busy_r;
   logic [RANGE_W-1:0]        range;

   assign req_take   = req_ch.valid && req_ch.ready;
   assign unit_start = state_ff == ST_LOAD;
   assign units_busy = busy_x || busy_y || busy_z || busy_r;
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign commit     = (state_ff == ST_WRITE) && rsp_free;
   assign sweep      = state_ff == ST_CLEAR;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (sweep) begin
            clr_cnt_ff <= clr_cnt_ff + VW'(1);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ch.ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == VW'(VOX_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD:  state_in = ST_CALC;
         ST_CALC: begin
            if (!units_busy) begin
               state_in = ST_READ;
            end
         end
         ST_READ:  state_in = ST_WRITE;  // stores read this cycle
         ST_WRITE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_CLEAR;
      endcase
   end

   // capture the point and form the offsets from the grid edges
   always_ff @(posedge clock) begin
      if (req_take) begin
         pidx_ff  <= req_ch.point_index;
         px_ff    <= req_ch.point_x;
         py_ff    <= req_ch.point_y;
         pz_ff    <= req_ch.point_z;
         off_x_ff <= OFF_W'(req_ch.point_x) - OFF_W'(origin_x_ff);
         off_y_ff <= OFF_W'(req_ch.point_y) - OFF_W'(top_y_ff);
         off_z_ff <= OFF_W'(req_ch.point_z) - OFF_W'(top_z_ff);
      end
   end

   assign mag_x = off_x_ff[OFF_W-1] ? OFF_W'(-off_x_ff) : OFF_W'(off_x_ff);
   assign mag_y = off_y_ff[OFF_W-1] ? OFF_W'(-off_y_ff) : OFF_W'(off_y_ff);
   assign mag_z = off_z_ff[OFF_W-1] ? OFF_W'(-off_z_ff) : OFF_W'(off_z_ff);

   pvb_div #(.DW(OFF_W), .SW(STEP_W)) u_div_x (
      .clock(clock), .reset(reset), .start(unit_start), .dividend(mag_x),
      .divisor(step_x_ff), .busy(busy_x), .quotient(quo_x));
   pvb_div #(.DW(OFF_W), .SW(STEP_W)) u_div_y (
      .clock(clock), .reset(reset), .start(unit_start), .dividend(mag_y),
      .divisor(step_y_ff), .busy(busy_y), .quotient(quo_y));
   pvb_div #(.DW(OFF_W), .SW(STEP_W)) u_div_z (
      .clock(clock), .reset(reset), .start(unit_start), .dividend(mag_z),
      .divisor(step_z_ff), .busy(busy_z), .quotient(quo_z));

   pvb_root u_root (
      .clock(clock), .reset(reset), .start(unit_start),
      .x(px_ff), .y(py_ff), .z(pz_ff), .busy(busy_r), .root(range));

   // bin checks; quotients hold once the dividers finish
   logic ok_x, ok_y, ok_z, in_range;
   logic [BXW-1:0] bin_x;
   logic [BYW-1:0] bin_y;
   logic [BZW-1:0] bin_z;

   // x offset below the origin is only allowed while it truncates to bin zero
   assign ok_x = (step_x_ff != '0) && !(off_x_ff[OFF_W-1] && quo_x != '0)
                 && (quo_x < OFF_W'(X_CELLS));
   assign ok_y = (step_y_ff != '0) && (quo_y < OFF_W'(Y_CELLS));
   assign ok_z = (step_z_ff != '0) && (quo_z < OFF_W'(Z_CELLS));
   assign in_range = ok_x && ok_y && ok_z;
   assign bin_x = quo_x[BXW-1:0];
   assign bin_y = quo_y[BYW-1:0];
   assign bin_z = quo_z[BZW-1:0];

   logic [VW-1:0] vox_addr;
   logic [FW-1:0] frt_addr;

   assign vox_addr = VW'(bin_x) * VW'(FRONTS) + VW'(bin_z) * VW'(Y_CELLS) + VW'(bin_y);
   assign frt_addr = FW'(bin_z) * FW'(Y_CELLS) + FW'(bin_y);

   // stores
   logic [VOX_W-1:0]  vox_rd, vox_wd;
   logic [FRT_W-1:0]  frt_rd, frt_wd;
   logic [HIST_W-1:0] hx_rd, hy_rd, hz_rd, hx_new, hy_new, hz_new;
   logic [HIT_W-1:0]  hits_old, hits_new;
   logic [FMW-1:0]    frt_min;
   logic              fresh, front_upd;
   logic              vox_we, frt_we, hx_we, hy_we, hz_we;
   logic              upd;

   assign hits_old  = vox_rd[HIT_W-1:0];
   assign fresh     = hits_old == '0;
   assign hits_new  = (hits_old == '1) ? hits_old : hits_old + HIT_W'(1);
   assign frt_min   = frt_rd[FRT_W-1 -: FMW];
   assign front_upd = {1'b0, bin_x} < frt_min;
   assign hx_new    = (hx_rd == '1) ? hx_rd : hx_rd + HIST_W'(1);
   assign hy_new    = (hy_rd == '1) ? hy_rd : hy_rd + HIST_W'(1);
   assign hz_new    = (hz_rd == '1) ? hz_rd : hz_rd + HIST_W'(1);

   // the clearing pass owns the write ports until it ends
   assign upd    = commit && in_range;
   assign vox_we = sweep || upd;
   assign frt_we = sweep ? (clr_cnt_ff < VW'(FRONTS)) : (upd && front_upd);
   assign hx_we  = sweep ? (clr_cnt_ff < VW'(X_CELLS)) : upd;
   assign hy_we  = sweep ? (clr_cnt_ff < VW'(Y_CELLS)) : upd;
   assign hz_we  = sweep ? (clr_cnt_ff < VW'(Z_CELLS)) : upd;
   assign vox_wd = sweep ? '0 : {pidx_ff, hits_new};
   assign frt_wd = sweep ? {{FMW{1'b1}}, {(INDEX_W + RANGE_W){1'b0}}}
                         : {{1'b0, bin_x}, pidx_ff, range};

   pvb_ram #(.WIDTH(VOX_W), .DEPTH(VOX_DEPTH)) u_vox_ram (
      .clock(clock), .wr_en(vox_we), .wr_addr(sweep ? clr_cnt_ff : vox_addr),
      .wr_data(vox_wd), .rd_addr(vox_addr), .rd_data(vox_rd));
   pvb_ram #(.WIDTH(FRT_W), .DEPTH(FRONTS)) u_front_ram (
      .clock(clock), .wr_en(frt_we), .wr_addr(sweep ? clr_cnt_ff[FW-1:0] : frt_addr),
      .wr_data(frt_wd), .rd_addr(frt_addr), .rd_data(frt_rd));
   pvb_ram #(.WIDTH(HIST_W), .DEPTH(X_CELLS)) u_hist_x_ram (
      .clock(clock), .wr_en(hx_we), .wr_addr(sweep ? clr_cnt_ff[BXW-1:0] : bin_x),
      .wr_data(sweep ? '0 : hx_new), .rd_addr(bin_x), .rd_data(hx_rd));
   pvb_ram #(.WIDTH(HIST_W), .DEPTH(Y_CELLS)) u_hist_y_ram (
      .clock(clock), .wr_en(hy_we), .wr_addr(sweep ? clr_cnt_ff[BYW-1:0] : bin_y),
      .wr_data(sweep ? '0 : hy_new), .rd_addr(bin_y), .rd_data(hy_rd));
   pvb_ram #(.WIDTH(HIST_W), .DEPTH(Z_CELLS)) u_hist_z_ram (
      .clock(clock), .wr_en(hz_we), .wr_addr(sweep ? clr_cnt_ff[BZW-1:0] : bin_z),
      .wr_data(sweep ? '0 : hz_new), .rd_addr(bin_z), .rd_data(hz_rd));

   // output register
   logic [BXW-1:0]     o_bin_x_ff;
   logic [BYW-1:0]     o_bin_y_ff;
   logic [BZW-1:0]     o_bin_z_ff;
   logic [HIT_W-1:0]   o_hits_ff;
   logic               o_fresh_ff, o_front_ff, o_oor_ff;
   logic [RANGE_W-1:0] o_range_ff;
   logic [HIST_W-1:0]  o_hx_ff, o_hy_ff, o_hz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         // out of range points report only their range
         o_bin_x_ff <= in_range ? bin_x : '0;
         o_bin_y_ff <= in_range ? bin_y : '0;
         o_bin_z_ff <= in_range ? bin_z : '0;
         o_hits_ff  <= in_range ? hits_new : '0;
         o_fresh_ff <= in_range && fresh;
         o_front_ff <= in_range && front_upd;
         o_oor_ff   <= !in_range;
         o_range_ff <= range;
         o_hx_ff    <= in_range ? hx_new : '0;
         o_hy_ff    <= in_range ? hy_new : '0;
         o_hz_ff    <= in_range ? hz_new : '0;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.bin_x         = o_bin_x_ff;
   assign rsp_ch.bin_y         = o_bin_y_ff;
   assign rsp_ch.bin_z         = o_bin_z_ff;
   assign rsp_ch.voxel_hits    = o_hits_ff;
   assign rsp_ch.new_voxel     = o_fresh_ff;
   assign rsp_ch.front_updated = o_front_ff;
   assign rsp_ch.point_range   = o_range_ff;
   assign rsp_ch.out_of_range  = o_oor_ff;
   assign rsp_ch.x_hist_count  = o_hx_ff;
   assign rsp_ch.y_hist_count  = o_hy_ff;
   assign rsp_ch.z_hist_count  = o_hz_ff;
endmodule

// File: test/tb.sv
// self-checking testbench of the point voxel binning unit
`timescale 1ns / 100ps

module tb;
   import pvb_pkg::*;

   localparam int XC = X_CELLS_DEF;
   localparam int YC = Y_CELLS_DEF;
   localparam int ZC = Z_CELLS_DEF;
   localparam int HIT_MAX  = 65535;
   localparam int HIST_MAX = 1048575;
   localparam logic [6:0] FRONT_EMPTY = 7'd127;

   typedef struct {
      logic [INDEX_W-1:0]        index;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_word_type;

   typedef struct {
      logic [5:0]         bin_x;
      logic [5:0]         bin_y;
      logic [5:0]         bin_z;
      logic [HIT_W-1:0]   voxel_hits;
      logic               new_voxel;
      logic               front_updated;
      logic [RANGE_W-1:0] point_range;
      logic               out_of_range;
      logic [HIST_W-1:0]  x_hist;
      logic [HIST_W-1:0]  y_hist;
      logic [HIST_W-1:0]  z_hist;
   } bin_word_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   pvb_req_if req_ch ();
   pvb_rsp_if rsp_ch ();

   point_voxel_binning_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // our own copy of the grid registers and the stores
   longint      grid_org_x, grid_top_y, grid_top_z;
   int unsigned grid_step_x, grid_step_y, grid_step_z;
   logic [HIT_W-1:0]  voxel_hits_m [XC*YC*ZC];
   logic [6:0]        front_bin_m [YC*ZC];
   logic [HIST_W-1:0] x_hist_m [XC];
   logic [HIST_W-1:0] y_hist_m [YC];
   logic [HIST_W-1:0] z_hist_m [ZC];

   point_word_type points_todo [$];   // words still to be offered
   bin_word_type   bins_due [$];      // predicted words, oldest first
   point_word_type recent_points [$]; // pool for hitting the same voxel again

   int  errors = 0;
   bit  req_busy = 0;
   bit  req_took = 0;
   bit  rsp_took = 0;
   int  req_gap = 0;
   int  rsp_wait = 0;
   int  hold_long = 0;
   bit  calm = 0;

   initial begin
      req_ch.valid = 0;
      req_ch.point_index = '0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      req_ch.point_z = '0;
      rsp_ch.ready = 0;
      grid_org_x = 0;
      grid_top_y = 0;
      grid_top_z = 0;
      grid_step_x = 10;
      grid_step_y = 10;
      grid_step_z = 10;
      foreach (voxel_hits_m[i]) voxel_hits_m[i] = '0;
      foreach (front_bin_m[i]) front_bin_m[i] = FRONT_EMPTY;
      foreach (x_hist_m[i]) x_hist_m[i] = '0;
      foreach (y_hist_m[i]) y_hist_m[i] = '0;
      foreach (z_hist_m[i]) z_hist_m[i] = '0;
   end

   initial begin
      forever #6 clock = ~clock;
   end

   // floor square root, one result bit per pass
   function automatic logic [RANGE_W-1:0] floor_root(longint unsigned n);
      longint unsigned root;
      longint unsigned b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n = n - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root[RANGE_W-1:0];
   endfunction

   // bin of an offset, -1 when it lies off the grid
   function automatic int cell_of(longint d, int unsigned step, bit use_abs, int cells);
      longint unsigned mag;
      longint unsigned q;
      if (step == 0) return -1;
      mag = (d < 0) ? -d : d;
      q = mag / step;
      if (d < 0 && !use_abs && q != 0) return -1;
      if (q >= cells) return -1;
      return int'(q);
   endfunction

   // work out the word for one accepted point and update our stores
   task automatic bin_point(point_word_type p);
      bin_word_type w;
      longint x, y, z;
      int bx, by, bz, vi, fi;
      x = p.x;
      y = p.y;
      z = p.z;
      w = '{default: '0};
      w.point_range = floor_root(x*x + y*y + z*z);
      bx = cell_of(x - grid_org_x, grid_step_x, 0, XC);
      by = cell_of(y - grid_top_y, grid_step_y, 1, YC);
      bz = cell_of(z - grid_top_z, grid_step_z, 1, ZC);
      if (bx < 0 || by < 0 || bz < 0) begin
         w.out_of_range = 1;
      end else begin
         vi = bx*YC*ZC + bz*YC + by;
         fi = bz*YC + by;
         w.new_voxel = (voxel_hits_m[vi] == 0);
         if (voxel_hits_m[vi] < HIT_MAX) voxel_hits_m[vi] = voxel_hits_m[vi] + 1;
         w.front_updated = (bx < front_bin_m[fi]);
         if (w.front_updated) front_bin_m[fi] = bx[6:0];
         if (x_hist_m[bx] < HIST_MAX) x_hist_m[bx] = x_hist_m[bx] + 1;
         if (y_hist_m[by] < HIST_MAX) y_hist_m[by] = y_hist_m[by] + 1;
         if (z_hist_m[bz] < HIST_MAX) z_hist_m[bz] = z_hist_m[bz] + 1;
         w.bin_x = bx[5:0];
         w.bin_y = by[5:0];
         w.bin_z = bz[5:0];
         w.voxel_hits = voxel_hits_m[vi];
         w.x_hist = x_hist_m[bx];
         w.y_hist = y_hist_m[by];
         w.z_hist = z_hist_m[bz];
      end
      bins_due = {bins_due, w};
   endtask

   task automatic check_field(string name, logic [19:0] e, logic [19:0] a);
      if (a !== e) begin
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, e, a);
         errors++;
      end
   endtask

   // request driver: one word at a time, random gap after each accept unless calm is set
   always @(negedge clock) begin
      point_word_type p;
      if (reset) begin
         req_ch.valid <= 0;
      end else begin
         if (req_busy && req_took) begin
            req_busy = 0;
            req_gap = calm ? 0 : $urandom_range(0, 8);
         end
         req_took = 0;
         if (!req_busy) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (points_todo.size() > 0) begin
               p = points_todo.pop_front();
               req_ch.point_index <= p.index;
               req_ch.point_x <= p.x;
               req_ch.point_y <= p.y;
               req_ch.point_z <= p.z;
               req_busy = 1;
            end
         end
         req_ch.valid <= req_busy;
      end
   end

   // response ready: random stall per word unless calm is set, plus an optional long hold-off
   always @(negedge clock) begin
      bit r;
      if (reset) begin
         rsp_ch.ready <= 0;
      end else begin
         if (rsp_took) begin
            rsp_took = 0;
            rsp_wait = calm ? 0 : $urandom_range(0, 8);
         end
         if (hold_long > 0) begin
            hold_long--;
            r = 0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            r = 0;
         end else begin
            r = 1;
         end
         rsp_ch.ready <= r;
      end
   end

   // sample both handshakes at the rising edge
   always @(posedge clock) begin
      point_word_type p;
      bin_word_type e;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            p.index = req_ch.point_index;
            p.x = req_ch.point_x;
            p.y = req_ch.point_y;
            p.z = req_ch.point_z;
            bin_point(p);
            req_took = 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_took = 1;
            if (bins_due.size() == 0) begin
               $display("%0t unexpected word: no prediction waiting, actual bins %0d %0d %0d",
                        $time, rsp_ch.bin_x, rsp_ch.bin_y, rsp_ch.bin_z);
               errors++;
            end else begin
               e = bins_due.pop_front();
               check_field("bin_x", e.bin_x, rsp_ch.bin_x);
               check_field("bin_y", e.bin_y, rsp_ch.bin_y);
               check_field("bin_z", e.bin_z, rsp_ch.bin_z);
               check_field("voxel_hits", e.voxel_hits, rsp_ch.voxel_hits);
               check_field("new_voxel", e.new_voxel, rsp_ch.new_voxel);
               check_field("front_updated", e.front_updated, rsp_ch.front_updated);
               check_field("point_range", e.point_range, rsp_ch.point_range);
               check_field("out_of_range", e.out_of_range, rsp_ch.out_of_range);
               check_field("x_hist_count", e.x_hist, rsp_ch.x_hist_count);
               check_field("y_hist_count", e.y_hist, rsp_ch.y_hist_count);
               check_field("z_hist_count", e.z_hist, rsp_ch.z_hist_count);
            end
         end
      end
   end

   // register write, mirrored into our copy of the grid
   task automatic csr_write(csr_index_type idx, logic [CSR_DW-1:0] val);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_ORIGIN_X: grid_org_x = longint'(signed'(val));
         CSR_TOP_Y:    grid_top_y = longint'(signed'(val));
         CSR_TOP_Z:    grid_top_z = longint'(signed'(val));
         CSR_STEP_X:   grid_step_x = val[STEP_W-1:0];
         CSR_STEP_Y:   grid_step_y = val[STEP_W-1:0];
         CSR_STEP_Z:   grid_step_z = val[STEP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic set_grid(logic [19:0] ox, logic [19:0] ty, logic [19:0] tz,
                           logic [15:0] sx, logic [15:0] sy, logic [15:0] sz);
      csr_write(CSR_ORIGIN_X, ox);
      csr_write(CSR_TOP_Y, ty);
      csr_write(CSR_TOP_Z, tz);
      csr_write(CSR_STEP_X, sx);
      csr_write(CSR_STEP_Y, sy);
      csr_write(CSR_STEP_Z, sz);
   endtask

   // append one word to the pending queue
   task automatic add_point(point_word_type p);
      points_todo = {points_todo, p};
   endtask

   // waits until every queued point is sent and every predicted word is back, then lets the block settle
   task automatic drain();
      while (points_todo.size() > 0 || req_busy || bins_due.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic point_word_type pt(int unsigned idx, int x, int y, int z);
      point_word_type p;
      p.index = INDEX_W'(idx);
      p.x = COORD_W'(x);
      p.y = COORD_W'(y);
      p.z = COORD_W'(z);
      return p;
   endfunction

   // keep a coordinate if it fits the field, else any value
   function automatic logic signed [19:0] fit(longint v);
      if (v < -524288 || v > 524287) return 20'($urandom_range(0, 20'hFFFFF));
      return v[19:0];
   endfunction

   // coordinate aimed at a random cell of the current grid
   function automatic logic signed [19:0] aim(longint base, int unsigned step, bit two_sided);
      longint off;
      if (step == 0) return 20'($urandom_range(0, 20'hFFFFF));
      off = longint'($urandom_range(0, 63)) * step + $urandom_range(0, step - 1);
      if (two_sided && $urandom_range(0, 1)) off = -off;
      return fit(base + off);
   endfunction

   function automatic point_word_type random_point();
      point_word_type p;
      int unsigned sel;
      sel = $urandom_range(0, 99);
      p.index = INDEX_W'($urandom_range(0, 20'hFFFFF));
      if (sel < 15) begin
         p.x = COORD_W'($urandom_range(0, 20'hFFFFF));
         p.y = COORD_W'($urandom_range(0, 20'hFFFFF));
         p.z = COORD_W'($urandom_range(0, 20'hFFFFF));
      end else if (sel < 40 && recent_points.size() > 0) begin
         p = recent_points[$urandom_range(0, recent_points.size() - 1)];
         p.index = INDEX_W'($urandom_range(0, 20'hFFFFF));
         // sometimes step back along x to take over the front cell
         if ($urandom_range(0, 1)) p.x = fit(longint'(p.x) - grid_step_x);
      end else begin
         p.x = aim(grid_org_x, grid_step_x, 0);
         p.y = aim(grid_top_y, grid_step_y, 1);
         p.z = aim(grid_top_z, grid_step_z, 1);
      end
      if (recent_points.size() >= 16) void'(recent_points.pop_front());
      recent_points = {recent_points, p};
      return p;
   endfunction

   task automatic random_phase(int n);
      repeat (n) add_point(random_point());
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed points at the reset grid: origin 0, steps of 10
      add_point(pt(0, 0, 0, 0));
      add_point(pt(1, 0, 0, 0));           // same voxel again
      add_point(pt(2, -5, 3, 3));          // small negative x offset, bin 0
      add_point(pt(3, -10, 0, 0));         // negative x bin
      add_point(pt(4, 639, 639, 639));     // top corner of the grid
      add_point(pt(5, 640, 0, 0));         // x just off the grid
      add_point(pt(6, 0, -639, -639));     // magnitude of negative y and z
      add_point(pt(7, 0, 640, 0));
      add_point(pt(8, 0, 0, -640));
      add_point(pt(9, 300, 15, 25));
      add_point(pt(10, 200, 15, 25));      // nearer in the same front cell
      add_point(pt(11, 400, 15, 25));      // farther, front kept
      add_point(pt(20'hFFFFF, 524287, 524287, 524287));
      add_point(pt(13, -524288, -524288, -524288));
      add_point(pt(14, 1, -1, 1));
      drain();

      // zero steps flag every point
      set_grid(0, 0, 0, 0, 10, 10);
      add_point(pt(15, 5, 5, 5));
      drain();
      csr_write(CSR_STEP_X, 10);
      drain();
      set_grid(0, 0, 0, 10, 0, 0);
      add_point(pt(16, 5, 5, 5));
      drain();

      // widest cells at the low end of the field
      set_grid(20'h80000, 20'h7FFFF, 20'h80000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_point(pt(17, -524288, 524287, -524288));
      add_point(pt(18, 524287, -524288, 524287));
      random_phase(60);

      // single millimetre cells at the high end
      set_grid(20'h7FFC0, 20'h7FFFF, 20'h7FFFF, 1, 1, 1);
      add_point(pt(19, 524287, 524287, 524287));
      random_phase(60);

      // back pressure: receiver holds off while points keep coming
      set_grid(0, 0, 0, 10, 10, 10);
      hold_long = 300;
      random_phase(90);

      // no idling on either side
      calm = 1;
      set_grid(-200, 300, -100, 7, 13, 3);
      random_phase(90);
      calm = 0;

      repeat (4) begin
         set_grid($urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF),
                  $urandom_range(0, 20'hFFFFF), $urandom_range(1, 300),
                  $urandom_range(1, 300), $urandom_range(1, 300));
         random_phase(80);
      end

      repeat (60) @(posedge clock);
      if (errors == 0 && bins_due.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // overall limit, covering the clearing pass after reset
   initial begin
      #12_000_000;
      $display("%0t timeout, %0d words outstanding", $time, bins_due.size());
      $display("tb: errors");
      $finish;
   end

endmodule
